// ===== hw/rtl/saou_pkg.sv =====
// ----------------------------------------------------------------------------
// Alternating-order string argsort: shared package
// Sizes, widths and stream layout used by the sort unit and its RAMs.
// ----------------------------------------------------------------------------
`default_nettype none

package saou_pkg;

  localparam int MAX_STRINGS = 64;
  localparam int MAX_LENGTH  = 16;
  localparam int KEY_DEPTH   = MAX_STRINGS * MAX_LENGTH;

  // Field widths fixed by the stream and register layout.
  localparam int CHAR_W  = 8;
  localparam int COUNT_W = 7;
  localparam int LEN_W   = 5;
  localparam int POS_W   = 7;
  localparam int DATA_W  = 8;
  localparam int CFG_W   = 7;

  // Derived internal widths.
  localparam int IDX_W   = $clog2(MAX_STRINGS);
  localparam int KADDR_W = $clog2(KEY_DEPTH);
  localparam int K_W     = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
  localparam int TOTAL_W = COUNT_W + LEN_W;

  // Configuration register indexes.
  localparam logic CFG_STRING_COUNT  = 1'b0;
  localparam logic CFG_STRING_LENGTH = 1'b1;

endpackage

`default_nettype wire

// ===== hw/rtl/saou_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module saou_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/string_argsort_alternating_order_unit.sv =====
// ----------------------------------------------------------------------------
// Alternating-order string argsort unit
// Loads a set of equal-length strings, ranks them with one shared character
// comparator, and streams out the 1-based input position in sorted order.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Carries
//  ---------+-----------+--------------------------------------------------
//  s_*      | in        | one character per request, strings in order
//  m_*      | out       | original position (tdata), last of run (tlast)
//  cfg_*    | in        | register write: string count, string length
//
//  Loading accepts one character per cycle (count * length requests).
//  Sorting ranks every string against every other one with one comparator
//  fed by two key RAM reads; each compared character passes through a read
//  state (ST_READ) and a compare state (ST_COMPARE).
//  Each result then passes through ST_OUT_READ, ST_OUT_LOAD and ST_OUT_WAIT, which holds through any output stall.
//  s_tready is high only while loading. Reset is synchronous; the key and
//  rank RAMs are never cleared, only entries of the current set are read.
// ----------------------------------------------------------------------------
`default_nettype none

module string_argsort_alternating_order_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [saou_pkg::DATA_W-1:0]   s_tdata,   // [7:0] character
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic      [saou_pkg::DATA_W-1:0]   m_tdata,   // [6:0] original_position, [7] zero
  output logic                               m_tlast,
  input  wire logic                          cfg_write,
  input  wire logic                          cfg_index,
  input  wire logic [saou_pkg::CFG_W-1:0]    cfg_data
);

  localparam logic [2:0] ST_LOAD     = 3'd0;
  localparam logic [2:0] ST_READ     = 3'd1;
  localparam logic [2:0] ST_COMPARE  = 3'd2;
  localparam logic [2:0] ST_OUT_READ = 3'd3;
  localparam logic [2:0] ST_OUT_LOAD = 3'd4;
  localparam logic [2:0] ST_OUT_WAIT = 3'd5;

  logic [2:0]                          state;
  logic [saou_pkg::COUNT_W-1:0]        n_eff;
  logic [saou_pkg::LEN_W-1:0]          len_eff;
  logic [saou_pkg::KADDR_W-1:0]        load_count;
  logic [saou_pkg::IDX_W-1:0]          x;
  logic [saou_pkg::IDX_W-1:0]          y;
  logic [saou_pkg::K_W-1:0]            k;
  logic [saou_pkg::IDX_W-1:0]          cnt;
  logic [saou_pkg::IDX_W-1:0]          r;
  logic [saou_pkg::POS_W-1:0]          out_pos;
  logic                                out_last;

  logic [saou_pkg::TOTAL_W-1:0]        total;
  logic [saou_pkg::KADDR_W-1:0]        total_m1;
  logic [saou_pkg::COUNT_W-1:0]        n_m1;
  logic [saou_pkg::TOTAL_W-1:0]        addr_x_full;
  logic [saou_pkg::TOTAL_W-1:0]        addr_y_full;
  logic [saou_pkg::CHAR_W-1:0]         char_x;
  logic [saou_pkg::CHAR_W-1:0]         char_y;
  logic [saou_pkg::IDX_W-1:0]          rank_rdata;
  logic                                in_accept;
  logic                                out_accept;
  logic                                differ;
  logic                                y_before;
  logic                                decided;
  logic                                x_last;
  logic                                y_last;
  logic [saou_pkg::IDX_W-1:0]          cnt_next;
  logic                                rank_we;
  logic [saou_pkg::COUNT_W-1:0]        count_clamped;
  logic [saou_pkg::LEN_W-1:0]          length_clamped;

  assign in_accept  = s_tvalid && s_tready;
  assign out_accept = m_tvalid && m_tready;
  assign s_tready   = (state == ST_LOAD);
  assign m_tdata    = {{(saou_pkg::DATA_W - saou_pkg::POS_W){1'b0}}, out_pos};
  assign m_tlast    = out_last;

  // Out-of-range settings act as the nearest meaningful value (length: low LEN_W bits only).
  always_comb begin
    if (cfg_data == '0) begin
      count_clamped = saou_pkg::COUNT_W'(1);
    end else if (cfg_data > saou_pkg::COUNT_W'(saou_pkg::MAX_STRINGS)) begin
      count_clamped = saou_pkg::COUNT_W'(saou_pkg::MAX_STRINGS);
    end else begin
      count_clamped = cfg_data;
    end
    if (cfg_data[saou_pkg::LEN_W-1:0] == '0) begin
      length_clamped = saou_pkg::LEN_W'(1);
    end else if (cfg_data[saou_pkg::LEN_W-1:0] > saou_pkg::LEN_W'(saou_pkg::MAX_LENGTH)) begin
      length_clamped = saou_pkg::LEN_W'(saou_pkg::MAX_LENGTH);
    end else begin
      length_clamped = cfg_data[saou_pkg::LEN_W-1:0];
    end
  end

  assign total       = saou_pkg::TOTAL_W'(n_eff) * saou_pkg::TOTAL_W'(len_eff);
  assign total_m1    = saou_pkg::KADDR_W'(total - saou_pkg::TOTAL_W'(1));
  assign n_m1        = n_eff - saou_pkg::COUNT_W'(1);
  assign addr_x_full = saou_pkg::TOTAL_W'(x) * saou_pkg::TOTAL_W'(len_eff)
                       + saou_pkg::TOTAL_W'(k);
  assign addr_y_full = saou_pkg::TOTAL_W'(y) * saou_pkg::TOTAL_W'(len_eff)
                       + saou_pkg::TOTAL_W'(k);

  // Two copies of the key store give both characters of a pair in one read.
  saou_ram #(.WIDTH(saou_pkg::CHAR_W), .DEPTH(saou_pkg::KEY_DEPTH)) u_key_x (
    .clk   (clk),
    .we    (in_accept),
    .waddr (load_count),
    .wdata (s_tdata[saou_pkg::CHAR_W-1:0]),
    .raddr (addr_x_full[saou_pkg::KADDR_W-1:0]),
    .rdata (char_x)
  );

  saou_ram #(.WIDTH(saou_pkg::CHAR_W), .DEPTH(saou_pkg::KEY_DEPTH)) u_key_y (
    .clk   (clk),
    .we    (in_accept),
    .waddr (load_count),
    .wdata (s_tdata[saou_pkg::CHAR_W-1:0]),
    .raddr (addr_y_full[saou_pkg::KADDR_W-1:0]),
    .rdata (char_y)
  );

  // Rank of string x is the number of strings that go before it.
  // Even positions sort ascending, odd positions descending, ties by index.
  assign differ   = (char_x != char_y);
  assign y_before = differ ? (k[0] ? (char_y > char_x) : (char_y < char_x)) : (y < x);
  assign decided  = differ || (saou_pkg::LEN_W'(k) == len_eff - saou_pkg::LEN_W'(1));
  assign x_last   = (saou_pkg::COUNT_W'(x) == n_m1);
  assign y_last   = (saou_pkg::COUNT_W'(y) == n_m1);
  assign cnt_next = cnt + saou_pkg::IDX_W'(y_before);
  assign rank_we  = (state == ST_COMPARE) && decided && y_last;

  saou_ram #(.WIDTH(saou_pkg::IDX_W), .DEPTH(saou_pkg::MAX_STRINGS)) u_rank (
    .clk   (clk),
    .we    (rank_we),
    .waddr (cnt_next),
    .wdata (x),
    .raddr (r),
    .rdata (rank_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      n_eff      <= saou_pkg::COUNT_W'(1);
      len_eff    <= saou_pkg::LEN_W'(1);
      load_count <= '0;
      m_tvalid   <= 1'b0;
      x          <= '0;
      y          <= '0;
      k          <= '0;
      cnt        <= '0;
      r          <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        saou_pkg::CFG_STRING_COUNT:  n_eff   <= count_clamped;
        saou_pkg::CFG_STRING_LENGTH: len_eff <= length_clamped;
        default: ;
      endcase
      state      <= ST_LOAD;
      load_count <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      unique case (state)
        ST_LOAD: begin
          if (in_accept) begin
            if (load_count == total_m1) begin
              load_count <= '0;
              x          <= '0;
              y          <= '0;
              k          <= '0;
              cnt        <= '0;
              state      <= ST_READ;
            end else begin
              load_count <= load_count + saou_pkg::KADDR_W'(1);
            end
          end
        end
        ST_READ: begin
          state <= ST_COMPARE;
        end
        ST_COMPARE: begin
          state <= ST_READ;
          if (!decided) begin
            k <= k + saou_pkg::K_W'(1);
          end else begin
            k <= '0;
            if (!y_last) begin
              y   <= y + saou_pkg::IDX_W'(1);
              cnt <= cnt_next;
            end else begin
              y   <= '0;
              cnt <= '0;
              if (x_last) begin
                r     <= '0;
                state <= ST_OUT_READ;
              end else begin
                x <= x + saou_pkg::IDX_W'(1);
              end
            end
          end
        end
        ST_OUT_READ: begin
          state <= ST_OUT_LOAD;
        end
        ST_OUT_LOAD: begin
          m_tvalid <= 1'b1;
          out_pos  <= saou_pkg::POS_W'(rank_rdata) + saou_pkg::POS_W'(1);
          out_last <= (saou_pkg::COUNT_W'(r) == n_m1);
          state    <= ST_OUT_WAIT;
        end
        ST_OUT_WAIT: begin
          if (out_accept) begin
            m_tvalid <= 1'b0;
            if (out_last) begin
              state <= ST_LOAD;
            end else begin
              r     <= r + saou_pkg::IDX_W'(1);
              state <= ST_OUT_READ;
            end
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/saou_checker.sv =====
// ----------------------------------------------------------------------------
// Alternating-order string argsort: port checker
// Watches the top-level ports and flags sequencing errors.
// ----------------------------------------------------------------------------
`default_nettype none

module saou_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        s_tvalid,
  input wire logic                        s_tready,
  input wire logic                        m_tvalid,
  input wire logic                        m_tready,
  input wire logic [saou_pkg::DATA_W-1:0] m_tdata,
  input wire logic                        m_tlast,
  input wire logic                        cfg_write
);

  // The unit never loads while a result is on offer.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input ready while a result is pending");

  // A stalled result holds until taken or dropped by a register write.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready && !cfg_write |=>
      m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result changed");

  // After the last result of a run the unit is ready for the next set.
  a_ready_after_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tlast |=> s_tready && !m_tvalid)
    else $error("not ready to load after the last result");

  // Reset leaves the unit loading with no result pending.
  a_reset_state: assert property (@(posedge clk)
    rst |=> s_tready && !m_tvalid)
    else $error("wrong state after reset");

  // A reported position is always in 1..MAX_STRINGS.
  a_position_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata != '0) &&
      (m_tdata <= saou_pkg::DATA_W'(saou_pkg::MAX_STRINGS)))
    else $error("result position out of range");

endmodule

bind string_argsort_alternating_order_unit saou_checker u_saou_checker (.*);

`default_nettype wire

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// Alternating-order string argsort unit: self-checking testbench
// Loads string sets one character per request and ranks each set in a local
// predictor. Even character positions sort ascending, odd ones descending, and
// ties keep input order. Every returned position is checked in order against
// the prediction. Both stream sides stall at random. Register writes cover
// the size limits, including out-of-range values and a set cut short by a write.
// ----------------------------------------------------------------------------

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import saou_pkg::*;

  localparam int CYCLE_LIMIT   = 1500000;
  localparam int SETTLE_CYCLES = 8;
  localparam int ITEM_TARGET   = 350;
  localparam int RESULT_TARGET = 48;
  localparam int IDLE_PCT      = 18;

  typedef enum logic {ROW_WRITE, ROW_CHAR} row_kind_e;

  typedef struct packed {
    row_kind_e         kind;
    logic              reg_sel;
    logic [CFG_W-1:0]  value;
    logic [CHAR_W-1:0] ch;
    logic              typed;
    logic [POS_W-1:0]  pos;
    logic              last;
  } directed_row_t;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic             last;
  } rank_result_t;

  // Typed results appear only where a set holds a single string.
  localparam directed_row_t DIRECTED [31] = '{
    '{ROW_CHAR,  1'b0,              7'd0,    8'h00, 1'b1, 7'd1, 1'b1},
    '{ROW_CHAR,  1'b0,              7'd0,    8'hFF, 1'b1, 7'd1, 1'b1},
    '{ROW_WRITE, CFG_STRING_COUNT,  7'd3,    8'h00, 1'b0, 7'd0, 1'b0},
    '{ROW_WRITE, CFG_STRING_LENGTH, 7'd2,    8'h00, 1'b0, 7'd0, 1'b0},
    '{ROW_CHAR,  1'b0,              7'd0,    8'h10, 1'b0, 7'd0, 1'b0},
    '{ROW_CHAR,  1'b0,              7'd0,    8'h20, 1'b0, 7'd0, 1'b0},
    '{ROW_CHAR,  1'b0,              7'd0,    8'h10, 1'b0, 7'd0, 1'b0},
    '{ROW_CHAR,  1'b0,              7'd0,    8'h30, 1'b0, 7'd0, 1'b0},
    '{ROW_CHAR,  1'b0,              7'd0,    8'h05, 1'b0, 7'd0, 1'b0},
    '{ROW_CHAR,  1'b0,              7'd0,    8'h00, 1'b0, 7'd0, 1'b0},
    '{ROW_WRITE, CFG_STRING_COUNT,  7'd2,    8'h00, 1'b0, 7'd0, 1'b0},
    '{ROW_WRITE, CFG_STRING_LENGTH, 7'd1,    8'h00, 1'b0, 7'd0, 1'b0},
    '{ROW_CHAR,  1'b0,              7'd0,    8'h80, 1'b0, 7'd0, 1'b0},
    '{ROW_CHAR,  1'b0,              7'd0,    8'h80, 1'b0, 7'd0, 1'b0},
    '{ROW_WRITE, CFG_STRING_LENGTH, 7'd2,    8'h00, 1'b0, 7'd0, 1'b0},
    '{ROW_CHAR,  1'b0,              7'd0,    8'h7F, 1'b0, 7'd0, 1'b0},
    '{ROW_WRITE, CFG_STRING_LENGTH, 7'd1,    8'h00, 1'b0, 7'd0, 1'b0},
    '{ROW_CHAR,  1'b0,              7'd0,    8'h01, 1'b0, 7'd0, 1'b0},
    '{ROW_CHAR,  1'b0,              7'd0,    8'h00, 1'b0, 7'd0, 1'b0},
    '{ROW_WRITE, CFG_STRING_COUNT,  7'd0,    8'h00, 1'b0, 7'd0, 1'b0},
    '{ROW_WRITE, CFG_STRING_LENGTH, 7'd0,    8'h00, 1'b0, 7'd0, 1'b0},
    '{ROW_CHAR,  1'b0,              7'd0,    8'hAA, 1'b1, 7'd1, 1'b1},
    '{ROW_WRITE, CFG_STRING_COUNT,  7'd4,    8'h00, 1'b0, 7'd0, 1'b0},
    '{ROW_CHAR,  1'b0,              7'd0,    8'hFF, 1'b0, 7'd0, 1'b0},
    '{ROW_CHAR,  1'b0,              7'd0,    8'h00, 1'b0, 7'd0, 1'b0},
    '{ROW_CHAR,  1'b0,              7'd0,    8'hFF, 1'b0, 7'd0, 1'b0},
    '{ROW_CHAR,  1'b0,              7'd0,    8'h00, 1'b0, 7'd0, 1'b0},
    '{ROW_WRITE, CFG_STRING_COUNT,  7'd1,    8'h00, 1'b0, 7'd0, 1'b0},
    '{ROW_WRITE, CFG_STRING_LENGTH, 7'h62,   8'h00, 1'b0, 7'd0, 1'b0},
    '{ROW_CHAR,  1'b0,              7'd0,    8'h11, 1'b0, 7'd0, 1'b0},
    '{ROW_CHAR,  1'b0,              7'd0,    8'h22, 1'b1, 7'd1, 1'b1}
  };

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [DATA_W-1:0] s_tdata = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [DATA_W-1:0] m_tdata;
  logic              m_tlast;
  logic              cfg_write = 1'b0;
  logic              cfg_index = 1'b0;
  logic [CFG_W-1:0]  cfg_data = '0;

  // Local copy of the block's state.
  logic [CHAR_W-1:0]  key_copy [KEY_DEPTH];
  int unsigned        loaded = 0;
  logic [COUNT_W-1:0] count_reg = COUNT_W'(1);
  logic [LEN_W-1:0]   length_reg = LEN_W'(1);

  rank_result_t rank_queue [$];
  rank_result_t fresh_ranks [$];

  int    failures = 0;
  int    chars_sent = 0;
  int    results_seen = 0;
  int    sets_ranked = 0;
  bit    no_gaps = 1'b0;
  longint cycles = 0;

  string_argsort_alternating_order_unit uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int eff_count();
    if (count_reg == 0) return 1;
    if (count_reg > MAX_STRINGS) return MAX_STRINGS;
    return int'(count_reg);
  endfunction

  function automatic int eff_length();
    if (length_reg == 0) return 1;
    if (length_reg > MAX_LENGTH) return MAX_LENGTH;
    return int'(length_reg);
  endfunction

  // True when string a takes an earlier rank than string b.
  function automatic bit ranks_ahead(int a, int b, int len);
    logic [CHAR_W-1:0] ca;
    logic [CHAR_W-1:0] cb;
    for (int k = 0; k < len; k++) begin
      ca = key_copy[a * len + k];
      cb = key_copy[b * len + k];
      if (ca != cb) return (k % 2 == 0) ? (ca < cb) : (ca > cb);
    end
    return a < b;
  endfunction

  function automatic void absorb_char(logic [CHAR_W-1:0] ch);
    int n;
    int len;
    int total;
    int cur;
    int j;
    int order [MAX_STRINGS];
    n = eff_count();
    len = eff_length();
    total = n * len;
    if (loaded < total) key_copy[loaded] = ch;
    loaded++;
    if (loaded < total) return;
    for (int i = 0; i < n; i++) begin
      cur = i;
      j = i;
      while (j > 0 && ranks_ahead(cur, order[j - 1], len)) begin
        order[j] = order[j - 1];
        j--;
      end
      order[j] = cur;
    end
    for (int i = 0; i < n; i++)
      fresh_ranks.push_back(rank_result_t'{pos: POS_W'(order[i] + 1), last: (i == n - 1)});
    loaded = 0;
    sets_ranked++;
  endfunction

  function automatic logic [CHAR_W-1:0] pick_char(int style);
    int unsigned roll;
    roll = $urandom_range(3);
    // A narrow alphabet makes shared prefixes and full ties common.
    if (style == 1 || (style == 2 && $urandom_range(1) == 0)) begin
      case (roll)
        0: return 8'h00;
        1: return 8'h41;
        2: return 8'h42;
        default: return 8'hFF;
      endcase
    end
    return CHAR_W'($urandom_range(255));
  endfunction

  task automatic wait_for_ranks();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (rank_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic sel, logic [CFG_W-1:0] val);
    wait_for_ranks();
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    if (sel == CFG_STRING_COUNT) count_reg = val[COUNT_W-1:0];
    else length_reg = val[LEN_W-1:0];
    // Any write drops a partly loaded set.
    loaded = 0;
  endtask

  task automatic send_char(logic [CHAR_W-1:0] ch, logic typed, logic [POS_W-1:0] tpos,
                           logic tlast);
    @(negedge clk);
    while (!no_gaps && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= ch;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    chars_sent++;
    absorb_char(ch);
    if (typed && fresh_ranks.size() != 0) begin
      rank_queue.push_back(rank_result_t'{pos: tpos, last: tlast});
      fresh_ranks.delete();
    end else begin
      while (fresh_ranks.size() != 0) rank_queue.push_back(fresh_ranks.pop_front());
    end
  endtask

  task automatic send_set();
    logic [CHAR_W-1:0] text [KEY_DEPTH];
    int n;
    int len;
    int style;
    int src;
    n = eff_count();
    len = eff_length();
    style = $urandom_range(2);
    for (int s = 0; s < n; s++) begin
      if (s > 0 && $urandom_range(1) == 1) begin
        // Repeat an earlier string, sometimes with one character changed.
        src = $urandom_range(s - 1);
        for (int k = 0; k < len; k++) text[s * len + k] = text[src * len + k];
        if ($urandom_range(1) == 1) text[s * len + $urandom_range(len - 1)] = pick_char(style);
      end else begin
        for (int k = 0; k < len; k++) text[s * len + k] = pick_char(style);
      end
    end
    for (int i = 0; i < n * len; i++) send_char(text[i], 1'b0, '0, 1'b0);
  endtask

  task automatic send_partial();
    int total;
    total = eff_count() * eff_length();
    if (total > 1)
      repeat ($urandom_range(1, total - 1)) send_char(CHAR_W'($urandom_range(255)), 1'b0, '0,
                                                       1'b0);
  endtask

  task automatic pick_config(int unsigned phase_no, output logic [CFG_W-1:0] cnt,
                             output logic [CFG_W-1:0] len);
    int unsigned roll;
    roll = $urandom_range(19);
    case (phase_no)
      0: begin
        cnt = 7'd127;
        len = 7'd1;
      end
      1: begin
        cnt = 7'd64;
        len = 7'd2;
      end
      2: begin
        cnt = 7'd1;
        len = 7'd31;
      end
      3: begin
        cnt = 7'd0;
        len = 7'd0;
      end
      4: begin
        cnt = 7'd2;
        len = 7'd1;
      end
      default: begin
        if (roll < 14) begin
          cnt = CFG_W'($urandom_range(1, 8));
          len = CFG_W'($urandom_range(1, 4));
        end else if (roll < 18) begin
          cnt = CFG_W'($urandom_range(9, 24));
          len = CFG_W'($urandom_range(1, 8));
        end else begin
          cnt = CFG_W'($urandom_range(25, 127));
          len = CFG_W'($urandom_range(1, 2));
        end
        // Bits above the length register are dropped by the block.
        if ($urandom_range(4) == 0) len = len | (CFG_W'($urandom_range(3)) << LEN_W);
      end
    endcase
  endtask

  always @(negedge clk) begin
    m_tready <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    rank_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (rank_queue.size() == 0) begin
        failures++;
        $error("unexpected result: original_position %0d last_rank %0b",
               m_tdata[POS_W-1:0], m_tlast);
      end else begin
        want = rank_queue.pop_front();
        if (m_tdata !== DATA_W'(want.pos)) begin
          failures++;
          $error("original_position: expected %0d, actual %0d", want.pos, m_tdata);
        end
        if (m_tlast !== want.last) begin
          failures++;
          $error("last_rank: expected %0b, actual %0b", want.last, m_tlast);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("string_argsort_alternating_order_unit regression: fail");
      $finish;
    end
  end

  initial begin
    int unsigned      phase_no;
    int unsigned      sets;
    logic [CFG_W-1:0] count_val;
    logic [CFG_W-1:0] length_val;
    rst = 1'b1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[r]) begin
      if (DIRECTED[r].kind == ROW_WRITE) write_reg(DIRECTED[r].reg_sel, DIRECTED[r].value);
      else send_char(DIRECTED[r].ch, DIRECTED[r].typed, DIRECTED[r].pos, DIRECTED[r].last);
    end
    wait_for_ranks();

    phase_no = 0;
    while (chars_sent < ITEM_TARGET || results_seen < RESULT_TARGET) begin
      pick_config(phase_no, count_val, length_val);
      no_gaps = (phase_no == 1 || phase_no == 7);
      if ($urandom_range(1) == 1) begin
        write_reg(CFG_STRING_COUNT, count_val);
        write_reg(CFG_STRING_LENGTH, length_val);
      end else begin
        write_reg(CFG_STRING_LENGTH, length_val);
        write_reg(CFG_STRING_COUNT, count_val);
      end
      sets = (phase_no < 2) ? 1 : $urandom_range(1, 3);
      repeat (sets) begin
        send_set();
        if ($urandom_range(2) == 0) wait_for_ranks();
      end
      // A set cut short here is thrown away by the next phase's writes.
      if ($urandom_range(5) == 0) send_partial();
      phase_no++;
    end

    wait_for_ranks();
    no_gaps = 1'b0;
    repeat (20) @(posedge clk);

    $display("Ranked %0d string sets from %0d characters; %0d positions compared.",
             sets_ranked, chars_sent, results_seen);
    $display("Sizes ran from zero to past both limits, with ties, stalls and dropped sets.");
    if (failures == 0) begin
      $display("string_argsort_alternating_order_unit regression: pass");
    end else begin
      $display("string_argsort_alternating_order_unit regression: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/saou_pkg.sv
hw/rtl/saou_ram.sv
hw/rtl/string_argsort_alternating_order_unit.sv
hw/rtl/saou_checker.sv
bench/testbench.sv
